FILE: design/ssd4_pkg.sv
// Shared types, constants and glyph functions for the four-digit
// seven-segment frame driver. No dependencies.
package ssd4_pkg;

  localparam int DIGITS = 4;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_LETTER  = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_PATTERN = 3'd3,
    KIND_DIGIT   = 3'd4
  } kind_t;

  localparam logic [7:0] BLANK_SEG = 8'hFF;
  localparam logic signed [15:0] NUM_MAX = 16'sd9999;
  localparam logic signed [15:0] DIGIT_MAX = 16'sd9;

  localparam logic [7:0] LETTER_BASE = 8'd65;
  localparam logic [7:0] LOWER_A = 8'd97;
  localparam logic [7:0] LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] LETTER_COUNT = 8'd26;
  localparam logic [7:0] CHAR_LOWER_O = 8'h6F;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  localparam logic [16:0] RECIP10 = 17'd52429;
  localparam int SHIFT10 = 19;
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int SHIFT100 = 19;
  localparam logic [13:0] RECIP1000 = 14'd8389;
  localparam int SHIFT1000 = 23;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [7:0] LETTER_GLYPH [26] = '{
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h8B, 8'hCF, 8'hE1,
    8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h98, 8'hCC, 8'h92, 8'h87,
    8'hC1, 8'hD1, 8'hD5, 8'h89, 8'h91, 8'hB4
  };

  // Command after the reciprocal stage: the quotients of the number by
  // ten, a hundred and a thousand are ready for digit extraction.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  position;
    logic [7:0]  char_code;
    logic [7:0]  pattern;
    logic        negative;
    logic        too_big;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [13:0] n;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
  } split_t;

  typedef struct packed {
    logic [2:0]                  count;
    logic [DIGITS-1:0][7:0]      seg;
    logic [DIGITS-1:0][1:0]      pos;
  } frame_set_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    g = BLANK_SEG;
    if (d < 4'd10) begin
      g = DIGIT_GLYPH[d];
    end
    return g;
  endfunction

  function automatic logic [7:0] letter_seg(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] idx;
    logic [7:0] g;
    c = code;
    g = BLANK_SEG;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      c = c - CASE_OFFSET;
    end
    idx = c - LETTER_BASE;
    if (c >= LETTER_BASE && idx < LETTER_COUNT) begin
      g = LETTER_GLYPH[idx[4:0]];
    end
    return g;
  endfunction

  function automatic logic [7:0] select_byte(input logic [1:0] pos);
    logic [3:0] oh;
    oh = 4'b0001 << pos;
    return {4'hF, oh};
  endfunction

endpackage

FILE: design/ssd4_frame_build.sv
// Combinational frame builder: turns one split command into up to four
// segment frames. Depends on ssd4_pkg.
module ssd4_frame_build (
  input  ssd4_pkg::split_t     split,
  output ssd4_pkg::frame_set_t frames
);

  logic [6:0]  h7;
  logic [9:0]  t10;
  logic [13:0] u14;

  always_comb begin
    h7  = split.q100 - 7'(split.q1000) * 7'd10;
    t10 = split.q10 - 10'(split.q100) * 10'd10;
    u14 = split.n - 14'(split.q10) * 14'd10;
  end

  always_comb begin
    frames.count = 3'd0;
    for (int i = 0; i < ssd4_pkg::DIGITS; i++) begin
      frames.seg[i] = ssd4_pkg::BLANK_SEG;
      frames.pos[i] = 2'(i);
    end
    unique case (split.kind)
      ssd4_pkg::KIND_NUMBER: begin
        if (split.negative) begin
          frames.count  = 3'd1;
          frames.seg[0] = ssd4_pkg::digit_glyph(4'd0);
        end else if (split.too_big) begin
          frames.count  = 3'd2;
          frames.seg[0] = ssd4_pkg::letter_seg(ssd4_pkg::CHAR_LOWER_O);
          frames.pos[0] = 2'd2;
          frames.seg[1] = ssd4_pkg::letter_seg(ssd4_pkg::CHAR_LOWER_F);
          frames.pos[1] = 2'd3;
        end else begin
          frames.count  = 3'(ssd4_pkg::DIGITS);
          frames.seg[0] = ssd4_pkg::digit_glyph(split.q1000);
          frames.seg[1] = ssd4_pkg::digit_glyph(h7[3:0]);
          frames.seg[2] = ssd4_pkg::digit_glyph(t10[3:0]);
          frames.seg[3] = ssd4_pkg::digit_glyph(u14[3:0]);
        end
      end
      ssd4_pkg::KIND_LETTER: begin
        frames.count  = 3'd1;
        frames.seg[0] = ssd4_pkg::letter_seg(split.char_code);
        frames.pos[0] = split.position;
      end
      ssd4_pkg::KIND_CLEAR: begin
        frames.count = 3'(ssd4_pkg::DIGITS);
      end
      ssd4_pkg::KIND_PATTERN: begin
        frames.count  = 3'd1;
        frames.seg[0] = split.pattern;
        frames.pos[0] = split.position;
      end
      ssd4_pkg::KIND_DIGIT: begin
        frames.count  = 3'd1;
        frames.seg[0] = split.digit_ok ? ssd4_pkg::digit_glyph(split.digit)
                                       : ssd4_pkg::BLANK_SEG;
        frames.pos[0] = split.position;
      end
      default: begin
        frames.count = 3'd0;
      end
    endcase
  end

endmodule

FILE: design/seven_segment_four_digit_driver.sv
// Top level of the four-digit seven-segment frame driver: input register, reciprocal
// stage, frame builder and frame serialiser. Depends on ssd4_pkg and ssd4_frame_build.
// A command passes the input register and the reciprocal stage; the serialiser offers
// its frames. Throughput: one frame per cycle while frame_stall is low; the serialiser
// loads a command when idle or as its last frame goes; an unused kind gives no frames.
// Reset: synchronous; clears all valid flags, so no frame is offered after reset.
module seven_segment_four_digit_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  kind,
  input  logic signed [15:0] value,
  input  logic [1:0]  position,
  input  logic [7:0]  char_code,
  input  logic [7:0]  pattern,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  segments,
  output logic [7:0]  digit_select,
  output logic        last
);

  logic               a_valid;
  logic [2:0]         a_kind;
  logic signed [15:0] a_value;
  logic [1:0]         a_position;
  logic [7:0]         a_char_code;
  logic [7:0]         a_pattern;

  logic               b_valid;
  ssd4_pkg::split_t   b_split;
  ssd4_pkg::split_t   b_split_next;

  logic                 c_busy;
  ssd4_pkg::frame_set_t c_frames;
  logic [1:0]           c_idx;

  ssd4_pkg::frame_set_t b_frames;

  logic [30:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [13:0] a_n;

  logic item_accept;
  logic frame_accept;
  logic frame_last;
  logic c_free;
  logic b_ready;
  logic a_ready;
  logic b_load_c;

  always_comb begin
    a_n   = a_value[13:0];
    p10   = 31'(a_n) * 31'(ssd4_pkg::RECIP10);
    p100  = 27'(a_n) * 27'(ssd4_pkg::RECIP100);
    p1000 = 28'(a_n) * 28'(ssd4_pkg::RECIP1000);

    b_split_next.kind      = ssd4_pkg::kind_t'(a_kind);
    b_split_next.position  = a_position;
    b_split_next.char_code = a_char_code;
    b_split_next.pattern   = a_pattern;
    b_split_next.negative  = a_value < 16'sd0;
    b_split_next.too_big   = a_value > ssd4_pkg::NUM_MAX;
    b_split_next.digit_ok  = (a_value >= 16'sd0) && (a_value <= ssd4_pkg::DIGIT_MAX);
    b_split_next.digit     = a_value[3:0];
    b_split_next.n         = a_n;
    b_split_next.q10       = p10[ssd4_pkg::SHIFT10 +: 10];
    b_split_next.q100      = p100[ssd4_pkg::SHIFT100 +: 7];
    b_split_next.q1000     = p1000[ssd4_pkg::SHIFT1000 +: 4];
  end

  ssd4_frame_build u_frame_build (
    .split  (b_split),
    .frames (b_frames)
  );

  always_comb begin
    frame_last   = (3'(c_idx) + 3'd1) == c_frames.count;
    frame_accept = c_busy && !frame_stall;
    c_free       = !c_busy || (frame_accept && frame_last);
    b_load_c     = b_valid && (b_frames.count != 3'd0) && c_free;
    b_ready      = !b_valid || (b_frames.count == 3'd0) || c_free;
    a_ready      = !a_valid || b_ready;
    item_stall   = !a_ready;
    item_accept  = item_valid && a_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_accept) begin
      a_valid <= 1'b1;
    end else if (b_ready) begin
      a_valid <= 1'b0;
    end
    if (item_accept) begin
      a_kind      <= kind;
      a_value     <= value;
      a_position  <= position;
      a_char_code <= char_code;
      a_pattern   <= pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_split <= b_split_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_busy <= 1'b0;
      c_idx  <= 2'd0;
    end else if (b_load_c) begin
      c_busy <= 1'b1;
      c_idx  <= 2'd0;
    end else if (frame_accept) begin
      if (frame_last) begin
        c_busy <= 1'b0;
      end else begin
        c_idx <= c_idx + 2'd1;
      end
    end
    if (b_load_c) begin
      c_frames <= b_frames;
    end
  end

  assign frame_valid  = c_busy;
  assign segments     = c_frames.seg[c_idx];
  assign digit_select = ssd4_pkg::select_byte(c_frames.pos[c_idx]);
  assign last         = frame_last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    c_busy |-> (c_frames.count != 3'd0) && (c_frames.count <= 3'(ssd4_pkg::DIGITS)))
    else $error("Frame buffer holds an invalid frame count.");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    c_busy |-> (3'(c_idx) < c_frames.count))
    else $error("Frame index runs past the frame count.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (frame_accept && frame_last && !b_load_c) |=> !c_busy)
    else $error("Frame buffer still busy after its final beat.");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (frame_accept && !frame_last) |=> c_busy && (c_idx == 2'($past(c_idx) + 2'd1)))
    else $error("Frame index did not advance after a beat.");

  a_reset: assert property (@(posedge clk)
    rst |=> !frame_valid && !item_stall)
    else $error("Pipeline not empty after reset.");
`endif

endmodule

FILE: sim/ssd4_frame_checker.sv
// Frame checker for the four-digit seven-segment driver: watches the command
// and frame channels, predicts the frames of each command and compares them.
// Depends on ssd4_pkg for the command kinds.
module ssd4_frame_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [2:0]         kind,
  input  logic signed [15:0] value,
  input  logic [1:0]         position,
  input  logic [7:0]         char_code,
  input  logic [7:0]         pattern,
  input  logic               frame_valid,
  input  logic               frame_stall,
  input  logic [7:0]         segments,
  input  logic [7:0]         digit_select,
  input  logic               last,
  output int                 frames_pending,
  output int                 failures
);

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] sel;
    logic       fin;
  } frame_rec_t;

  localparam logic [7:0] BLANK = 8'hFF;

  localparam logic [7:0] NUMERAL_MAP [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [7:0] ALPHA_MAP [26] = '{
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h8B, 8'hCF, 8'hE1,
    8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h98, 8'hCC, 8'h92, 8'h87,
    8'hC1, 8'hD1, 8'hD5, 8'h89, 8'h91, 8'hB4
  };

  localparam logic [7:0] ENABLE_MAP [4] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

  frame_rec_t awaited_frames [$];

  function automatic logic [7:0] alpha_glyph(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      return ALPHA_MAP[c - 8'h41];
    end
    return BLANK;
  endfunction

  task automatic add_frame(input logic [7:0] seg, input logic [1:0] pos, input logic fin);
    frame_rec_t f;
    f.seg = seg;
    f.sel = ENABLE_MAP[pos];
    f.fin = fin;
    awaited_frames.push_back(f);
  endtask

  task automatic predict_frames(input logic [2:0] k, input logic signed [15:0] v,
                                input logic [1:0] pos, input logic [7:0] code,
                                input logic [7:0] pat);
    int n;
    n = v;
    unique case (k)
      ssd4_pkg::KIND_NUMBER: begin
        if (n < 0) begin
          add_frame(NUMERAL_MAP[0], 2'd0, 1'b1);
        end else if (n > 9999) begin
          add_frame(alpha_glyph(8'h6F), 2'd2, 1'b0);
          add_frame(alpha_glyph(8'h66), 2'd3, 1'b1);
        end else begin
          add_frame(NUMERAL_MAP[(n / 1000) % 10], 2'd0, 1'b0);
          add_frame(NUMERAL_MAP[(n / 100) % 10], 2'd1, 1'b0);
          add_frame(NUMERAL_MAP[(n / 10) % 10], 2'd2, 1'b0);
          add_frame(NUMERAL_MAP[n % 10], 2'd3, 1'b1);
        end
      end
      ssd4_pkg::KIND_LETTER: begin
        add_frame(alpha_glyph(code), pos, 1'b1);
      end
      ssd4_pkg::KIND_CLEAR: begin
        for (int i = 0; i < 4; i++) begin
          add_frame(BLANK, 2'(i), i == 3);
        end
      end
      ssd4_pkg::KIND_PATTERN: begin
        add_frame(pat, pos, 1'b1);
      end
      ssd4_pkg::KIND_DIGIT: begin
        if (n >= 0 && n <= 9) begin
          add_frame(NUMERAL_MAP[n], pos, 1'b1);
        end else begin
          add_frame(BLANK, pos, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_rec_t got;
    frame_rec_t want;
    if (rst) begin
      awaited_frames.delete();
    end else begin
      if (item_valid && !item_stall) begin
        predict_frames(kind, value, position, char_code, pattern);
      end
      if (frame_valid && !frame_stall) begin
        got.seg = segments;
        got.sel = digit_select;
        got.fin = last;
        if (awaited_frames.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("Unexpected frame: segments %h select %h last %b",
                     got.seg, got.sel, got.fin);
          end
        end else begin
          want = awaited_frames.pop_front();
          if (got.seg !== want.seg || got.sel !== want.sel || got.fin !== want.fin) begin
            failures++;
            if (failures <= 10) begin
              $display("Frame mismatch: expected %h/%h/%b, got %h/%h/%b",
                       want.seg, want.sel, want.fin, got.seg, got.sel, got.fin);
            end
          end
        end
      end
    end
    frames_pending <= awaited_frames.size();
  end

endmodule

FILE: sim/seven_segment_four_digit_driver_tb.sv
// Testbench top for the four-digit seven-segment driver: directed and random
// commands under several idling phases, checked by ssd4_frame_checker.
// Depends on ssd4_pkg, seven_segment_four_digit_driver and ssd4_frame_checker.
module seven_segment_four_digit_driver_tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [2:0]         kind = 3'd0;
  logic signed [15:0] value = 16'sd0;
  logic [1:0]         position = 2'd0;
  logic [7:0]         char_code = 8'd0;
  logic [7:0]         pattern = 8'd0;
  logic               frame_valid;
  logic               frame_stall = 1'b0;
  logic [7:0]         segments;
  logic [7:0]         digit_select;
  logic               last;
  int                 frames_pending;
  int                 failures;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  seven_segment_four_digit_driver dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .value(value), .position(position),
    .char_code(char_code), .pattern(pattern),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .segments(segments), .digit_select(digit_select), .last(last)
  );

  ssd4_frame_checker checker_i (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .value(value), .position(position),
    .char_code(char_code), .pattern(pattern),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .segments(segments), .digit_select(digit_select), .last(last),
    .frames_pending(frames_pending), .failures(failures)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    frame_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_command(input logic [2:0] k, input logic signed [15:0] v,
                              input logic [1:0] p, input logic [7:0] c,
                              input logic [7:0] pt);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    value <= v;
    position <= p;
    char_code <= c;
    pattern <= pt;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic drain_frames();
    item_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (frames_pending != 0);
  endtask

  task automatic send_random_commands(input int count);
    int sent;
    int pick;
    logic [2:0] k;
    logic signed [15:0] v;
    logic [1:0] p;
    logic [7:0] c;
    logic [7:0] pt;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      v = 16'($urandom);
      p = 2'($urandom);
      c = 8'($urandom);
      pt = 8'($urandom);
      sent++;
      if (pick < 30) begin
        k = ssd4_pkg::KIND_NUMBER;
        case ($urandom_range(4))
          0: v = 16'($urandom_range(9999));
          1: v = 16'($urandom_range(32767, 10000));
          2: v = -16'sd1 - 16'($urandom_range(32767));
          3: v = 16'($urandom_range(10010, 9990));
          default: begin
          end
        endcase
      end else if (pick < 50) begin
        k = ssd4_pkg::KIND_LETTER;
        case ($urandom_range(2))
          0: c = 8'h41 + 8'($urandom_range(25));
          1: c = 8'h61 + 8'($urandom_range(25));
          default: begin
          end
        endcase
      end else if (pick < 60) begin
        k = ssd4_pkg::KIND_CLEAR;
      end else if (pick < 75) begin
        k = ssd4_pkg::KIND_PATTERN;
      end else if (pick < 94) begin
        k = ssd4_pkg::KIND_DIGIT;
        if ($urandom_range(4) != 0) begin
          v = 16'($urandom_range(12)) - 16'sd1;
        end
      end else begin
        k = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      end
      send_command(k, v, p, c, pt);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_command(ssd4_pkg::KIND_NUMBER, 16'sd0, 2'd0, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_NUMBER, 16'sd9999, 2'd3, 8'hFF, 8'hFF);
    send_command(ssd4_pkg::KIND_NUMBER, 16'sd10000, 2'd1, 8'h55, 8'hAA);
    send_command(ssd4_pkg::KIND_NUMBER, 16'sd32767, 2'd2, 8'hAA, 8'h55);
    send_command(ssd4_pkg::KIND_NUMBER, -16'sd1, 2'd0, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_NUMBER, -16'sd32768, 2'd3, 8'hFF, 8'hFF);
    send_command(ssd4_pkg::KIND_NUMBER, 16'sd1234, 2'd0, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd0, 8'h61, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd3, 8'h7A, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd1, 8'h5A, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd2, 8'h40, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd0, 8'h5B, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd1, 8'h60, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd2, 8'h7B, 8'h00);
    send_command(ssd4_pkg::KIND_LETTER, 16'sd0, 2'd3, 8'hE1, 8'h00);
    send_command(ssd4_pkg::KIND_CLEAR, 16'sd0, 2'd0, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_PATTERN, 16'sd0, 2'd1, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_PATTERN, 16'sd0, 2'd2, 8'h00, 8'hFF);
    send_command(ssd4_pkg::KIND_PATTERN, 16'sd0, 2'd3, 8'h00, 8'hA5);
    send_command(ssd4_pkg::KIND_DIGIT, 16'sd0, 2'd0, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_DIGIT, 16'sd9, 2'd1, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_DIGIT, 16'sd10, 2'd2, 8'h00, 8'h00);
    send_command(ssd4_pkg::KIND_DIGIT, -16'sd1, 2'd3, 8'h00, 8'h00);
    send_command(KIND_SPARE_LO, 16'sd0, 2'd0, 8'h00, 8'h00);
    send_command(KIND_SPARE_HI, 16'sd0, 2'd0, 8'h00, 8'h00);
    drain_frames();

    send_random_commands(86);
    drain_frames();
    send_idle_pct = 62;
    send_random_commands(86);
    drain_frames();
    send_idle_pct = 0;
    recv_stall_pct = 62;
    send_random_commands(86);
    drain_frames();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    send_random_commands(87);
    drain_frames();

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (failures == 0 && frames_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
